// ===== src/aitv_pkg.sv =====
// ----------------------------------------------------------------------------
// aitv_pkg
// Types and codes shared by the animation index track validator and its
// channel interfaces.
// ----------------------------------------------------------------------------
package aitv_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_FORMAT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_COUNT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPATCHED_ONLY = 2'd2;

    localparam logic [8:0] TABLE_MAX = 9'd256;

    localparam logic [3:0] OP_CONSTANT = 4'd1;
    localparam logic [3:0] OP_KEY      = 4'd6;

    localparam logic [2:0] TY_INT16  = 3'd1;
    localparam logic [2:0] TY_UINT16 = 3'd2;
    localparam logic [2:0] TY_INT8   = 3'd3;
    localparam logic [2:0] TY_UINT8  = 3'd4;

    localparam logic [4:0] FRAC_INVALID = 5'd31;
    localparam logic [7:0] EXP_SPECIAL  = 8'd255;
    localparam logic [7:0] EXP_ONE      = 8'd127;
    localparam logic [7:0] EXP_MAX      = 8'd142;
    localparam logic [7:0] EXP_POINT    = 8'd150;

    typedef enum logic [3:0] {
        ST_RUNNING      = 4'd0,
        ST_VALID        = 4'd1,
        ST_NO_TABLE     = 4'd2,
        ST_BAD_FORMAT   = 4'd3,
        ST_TRUNCATED    = 4'd4,
        ST_VARINT_LIMIT = 4'd5,
        ST_BAD_OPCODE   = 4'd6,
        ST_OUT_OF_TABLE = 4'd7,
        ST_PKT_TRUNC    = 4'd8,
        ST_TOO_FEW      = 4'd9
    } status_t;

    typedef enum logic [4:0] {
        PH_HEADER     = 5'b00001,
        PH_COUNT      = 5'b00010,
        PH_VALUE      = 5'b00100,
        PH_WAIT_START = 5'b01000,
        PH_WAIT_CONT  = 5'b10000
    } phase_t;

endpackage

// ===== src/aitv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// aitv_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface aitv_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [aitv_pkg::CFG_INDEX_W-1:0]    index;
    logic [aitv_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/aitv_in_if.sv =====
// ----------------------------------------------------------------------------
// aitv_in_if
// Track byte channel: one item is one byte of the track stream.
// ----------------------------------------------------------------------------
interface aitv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/aitv_out_if.sv =====
// ----------------------------------------------------------------------------
// aitv_out_if
// Result channel: one status item for each track byte.
// ----------------------------------------------------------------------------
interface aitv_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic       track_done;

    modport source (output valid, output status, output track_done, input ready);
    modport sink   (input valid, input status, input track_done, output ready);
endinterface

// ===== src/anim_index_track_validator.sv =====
// ----------------------------------------------------------------------------
// anim_index_track_validator
// Byte-serial checker for packed animation index tracks.
// ----------------------------------------------------------------------------
// The block takes one track byte per cycle while the result channel is not
// stalled, and returns one status item per byte, in order. A byte is held in
// an input register, decoded combinationally against the parse state and its
// status placed in a result register, from which its status item is
// presented; the sustained rate is one item per clock while the result side
// accepts. Status is zero while a track is running and error-free; the first
// error found is held and reported for every later byte of that track. The
// byte flagged as last reports valid or the final error and starts a fresh
// track after it. Configuration is written through its own channel, which is
// always ready.
// ----------------------------------------------------------------------------
module anim_index_track_validator (
    input  logic            clk,
    input  logic            rst_n,
    aitv_cfg_if.sink        cfg,
    aitv_in_if.sink         track,
    aitv_out_if.source      result
);

    logic [7:0]             value_format_reg;
    logic [8:0]             table_count_reg;
    logic                   dispatched_only_reg;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;

    logic                   out_valid_reg;
    aitv_pkg::status_t      out_status_reg;
    logic                   out_done_reg;

    aitv_pkg::phase_t       phase_reg, phase_next, cur_phase;
    logic                   start_reg;
    logic [15:0]            entries_reg, entries_next, cur_entries;
    logic [21:0]            accum_reg, accum_next, cur_accum;
    logic [4:0]             shift_reg, shift_next, cur_shift;
    logic [1:0]             bytes_left_reg, bytes_left_next, cur_bytes_left;
    logic [31:0]            bits_reg, bits_next, cur_bits;
    logic [1:0]             tally_reg, tally_next, cur_tally;
    logic [2:0]             first_op_reg, first_op_next, cur_first_op;
    aitv_pkg::status_t      err_reg, err_next, cur_err;

    logic                   advance;
    logic [2:0]             fmt_type;
    logic [4:0]             fmt_frac;
    logic                   fmt_ok;
    logic [1:0]             len_minus_one;
    logic [31:0]            shifted_bits;
    logic [31:0]            raw;
    logic [8:0]             lim;
    logic [15:0]            cand;
    logic                   whole;
    logic                   val_ok;
    logic [7:0]             exp_f;
    logic [22:0]            man_f;
    logic [4:0]             sh_f;
    logic [23:0]            full_f;
    logic [31:0]            int_v;
    logic [21:0]            var_sum;
    logic [4:0]             var_shift;
    logic [3:0]             op;
    aitv_pkg::status_t      fin_code;
    aitv_pkg::status_t      status_next;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign track.ready  = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.track_done = out_done_reg;

    // config checks
    assign fmt_type = value_format_reg[7:5];
    assign fmt_frac = value_format_reg[4:0];
    assign fmt_ok   = (value_format_reg == 8'd0)
                   || ((fmt_type >= aitv_pkg::TY_INT16) && (fmt_type <= aitv_pkg::TY_UINT8)
                       && (fmt_frac != aitv_pkg::FRAC_INVALID));
    always_comb
    begin
        if (value_format_reg == 8'd0)
            len_minus_one = 2'd3;
        else if (fmt_type == aitv_pkg::TY_INT16 || fmt_type == aitv_pkg::TY_UINT16)
            len_minus_one = 2'd1;
        else
            len_minus_one = 2'd0;
    end
    assign lim = (table_count_reg > aitv_pkg::TABLE_MAX) ? aitv_pkg::TABLE_MAX
                                                         : table_count_reg;

    // start of track: parse from cleared state
    assign cur_phase      = start_reg ? aitv_pkg::PH_HEADER  : phase_reg;
    assign cur_entries    = start_reg ? 16'd0                : entries_reg;
    assign cur_accum      = start_reg ? 22'd0                : accum_reg;
    assign cur_shift      = start_reg ? 5'd0                 : shift_reg;
    assign cur_bytes_left = start_reg ? 2'd0                 : bytes_left_reg;
    assign cur_bits       = start_reg ? 32'd0                : bits_reg;
    assign cur_tally      = start_reg ? 2'd0                 : tally_reg;
    assign cur_first_op   = start_reg ? 3'd0                 : first_op_reg;
    assign cur_err        = start_reg ? aitv_pkg::ST_RUNNING : err_reg;

    // value decode
    assign shifted_bits = {in_byte_reg, cur_bits[31:8]};
    always_comb
    begin
        raw = shifted_bits;
        if (len_minus_one == 2'd1)
            raw = {16'd0, shifted_bits[31:16]};
        else if (len_minus_one == 2'd0)
            raw = {24'd0, shifted_bits[31:24]};
    end

    assign exp_f  = raw[30:23];
    assign man_f  = raw[22:0];
    assign sh_f   = 5'(aitv_pkg::EXP_POINT - exp_f);
    assign full_f = {1'b1, man_f};

    always_comb
    begin
        whole = 1'b1;
        cand  = 16'd0;
        int_v = 32'd0;
        if (value_format_reg == 8'd0)
        begin
            if (exp_f == aitv_pkg::EXP_SPECIAL)
                whole = 1'b0;
            else if (exp_f == 8'd0 && man_f == 23'd0)
                cand = 16'd0;
            else if (raw[31] || exp_f < aitv_pkg::EXP_ONE || exp_f > aitv_pkg::EXP_MAX)
                whole = 1'b0;
            else
            begin
                whole = (full_f & ~(24'hFFFFFF << sh_f)) == 24'd0;
                cand  = 16'(full_f >> sh_f);
            end
        end
        else
        begin
            if (fmt_type == aitv_pkg::TY_INT16 || fmt_type == aitv_pkg::TY_UINT16)
            begin
                if (fmt_type == aitv_pkg::TY_INT16 && raw[15])
                    whole = 1'b0;
                int_v = {16'd0, raw[15:0]};
            end
            else
            begin
                if (fmt_type == aitv_pkg::TY_INT8 && raw[7])
                    whole = 1'b0;
                int_v = {24'd0, raw[7:0]};
            end
            if ((int_v & ~(32'hFFFFFFFF << fmt_frac)) != 32'd0)
                whole = 1'b0;
            cand = 16'(int_v >> fmt_frac);
        end
    end
    assign val_ok = whole && (dispatched_only_reg || (cand < {7'd0, lim}));

    // varint step
    assign var_sum   = cur_accum + (22'(in_byte_reg[6:0]) << cur_shift[3:0]);
    assign var_shift = cur_shift + 5'd7;
    assign op        = in_byte_reg[3:0];

    function automatic aitv_pkg::status_t finish_code(input logic [15:0] entries,
                                                      input logic [1:0]  tally,
                                                      input logic [2:0]  first_op);
        aitv_pkg::status_t code;
        code = aitv_pkg::ST_RUNNING;
        if (entries != 16'd0)
            code = aitv_pkg::ST_PKT_TRUNC;
        else if (!(tally >= 2'd2 || (tally == 2'd1 && {1'b0, first_op} == aitv_pkg::OP_KEY)))
            code = aitv_pkg::ST_TOO_FEW;
        return code;
    endfunction

    always_comb
    begin
        phase_next      = cur_phase;
        entries_next    = cur_entries;
        accum_next      = cur_accum;
        shift_next      = cur_shift;
        bytes_left_next = cur_bytes_left;
        bits_next       = cur_bits;
        tally_next      = cur_tally;
        first_op_next   = cur_first_op;
        err_next        = cur_err;
        fin_code        = finish_code(cur_entries, cur_tally, cur_first_op);
        if (cur_err == aitv_pkg::ST_RUNNING)
        begin
            if (table_count_reg == 9'd0)
                err_next = aitv_pkg::ST_NO_TABLE;
            else if (!fmt_ok)
                err_next = aitv_pkg::ST_BAD_FORMAT;
            else
            begin
                case (cur_phase)
                    aitv_pkg::PH_COUNT, aitv_pkg::PH_WAIT_CONT:
                    begin
                        accum_next = var_sum;
                        shift_next = var_shift;
                        if (var_sum[21:16] != 6'd0)
                            err_next = aitv_pkg::ST_VARINT_LIMIT;
                        else if (in_byte_reg[7])
                        begin
                            if (var_shift >= 5'd16)
                                err_next = aitv_pkg::ST_VARINT_LIMIT;
                            else if (in_last_reg)
                                err_next = aitv_pkg::ST_TRUNCATED;
                        end
                        else if (cur_phase == aitv_pkg::PH_COUNT)
                        begin
                            entries_next = var_sum[15:0];
                            if (in_last_reg)
                                err_next = aitv_pkg::ST_TRUNCATED;
                            else
                            begin
                                phase_next      = aitv_pkg::PH_VALUE;
                                bytes_left_next = len_minus_one;
                                bits_next       = 32'd0;
                            end
                        end
                        else if (in_last_reg)
                            err_next = fin_code;
                        else if (cur_entries != 16'd0)
                        begin
                            phase_next      = aitv_pkg::PH_VALUE;
                            bytes_left_next = len_minus_one;
                            bits_next       = 32'd0;
                        end
                        else
                            phase_next = aitv_pkg::PH_HEADER;
                    end
                    aitv_pkg::PH_VALUE:
                    begin
                        bits_next = shifted_bits;
                        if (cur_bytes_left != 2'd0)
                        begin
                            bytes_left_next = cur_bytes_left - 2'd1;
                            if (in_last_reg)
                                err_next = aitv_pkg::ST_TRUNCATED;
                        end
                        else if (!val_ok)
                            err_next = aitv_pkg::ST_OUT_OF_TABLE;
                        else
                        begin
                            if (cur_entries != 16'd0)
                                entries_next = cur_entries - 16'd1;
                            if (cur_tally < 2'd2)
                                tally_next = cur_tally + 2'd1;
                            if (in_last_reg)
                                err_next = finish_code(entries_next, tally_next, cur_first_op);
                            else
                                phase_next = aitv_pkg::PH_WAIT_START;
                        end
                    end
                    aitv_pkg::PH_WAIT_START:
                    begin
                        accum_next = 22'(in_byte_reg[6:0]);
                        shift_next = 5'd7;
                        if (in_byte_reg[7])
                        begin
                            if (in_last_reg)
                                err_next = aitv_pkg::ST_TRUNCATED;
                            else
                                phase_next = aitv_pkg::PH_WAIT_CONT;
                        end
                        else if (in_last_reg)
                            err_next = fin_code;
                        else if (cur_entries != 16'd0)
                        begin
                            phase_next      = aitv_pkg::PH_VALUE;
                            bytes_left_next = len_minus_one;
                            bits_next       = 32'd0;
                        end
                        else
                            phase_next = aitv_pkg::PH_HEADER;
                    end
                    default:
                    begin
                        if (op != aitv_pkg::OP_CONSTANT && op != aitv_pkg::OP_KEY)
                            err_next = aitv_pkg::ST_BAD_OPCODE;
                        else
                        begin
                            if (cur_first_op == 3'd0)
                                first_op_next = op[2:0];
                            accum_next = 22'(in_byte_reg[6:4]) + 22'd1;
                            phase_next = aitv_pkg::PH_HEADER;
                            if (in_byte_reg[7])
                            begin
                                shift_next = 5'd3;
                                if (in_last_reg)
                                    err_next = aitv_pkg::ST_TRUNCATED;
                                else
                                    phase_next = aitv_pkg::PH_COUNT;
                            end
                            else
                            begin
                                entries_next = 16'(in_byte_reg[6:4]) + 16'd1;
                                if (in_last_reg)
                                    err_next = aitv_pkg::ST_TRUNCATED;
                                else
                                begin
                                    phase_next      = aitv_pkg::PH_VALUE;
                                    bytes_left_next = len_minus_one;
                                    bits_next       = 32'd0;
                                end
                            end
                        end
                    end
                endcase
            end
        end
        if (err_next != aitv_pkg::ST_RUNNING)
            status_next = err_next;
        else if (in_last_reg)
            status_next = aitv_pkg::ST_VALID;
        else
            status_next = aitv_pkg::ST_RUNNING;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_format_reg    <= 8'd0;
            table_count_reg     <= 9'd1;
            dispatched_only_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                aitv_pkg::CFG_VALUE_FORMAT:    value_format_reg    <= cfg.data[7:0];
                aitv_pkg::CFG_TABLE_COUNT:     table_count_reg     <= cfg.data[8:0];
                aitv_pkg::CFG_DISPATCHED_ONLY: dispatched_only_reg <= cfg.data[0];
                default:                       ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (track.ready)
            in_valid_reg <= track.valid;
    end

    always_ff @(posedge clk)
    begin
        if (track.ready && track.valid)
        begin
            in_byte_reg <= track.data_byte;
            in_last_reg <= track.last_byte;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status_next;
            out_done_reg   <= in_last_reg;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= aitv_pkg::PH_HEADER;
            start_reg      <= 1'b1;
            entries_reg    <= 16'd0;
            accum_reg      <= 22'd0;
            shift_reg      <= 5'd0;
            bytes_left_reg <= 2'd0;
            bits_reg       <= 32'd0;
            tally_reg      <= 2'd0;
            first_op_reg   <= 3'd0;
            err_reg        <= aitv_pkg::ST_RUNNING;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            start_reg      <= in_last_reg;
            entries_reg    <= entries_next;
            accum_reg      <= accum_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            bits_reg       <= bits_next;
            tally_reg      <= tally_next;
            first_op_reg   <= first_op_next;
            err_reg        <= err_next;
        end
    end

endmodule

// ===== sim/anim_index_track_validator_test.sv =====
// ----------------------------------------------------------------------------
// anim_index_track_validator_test
// Self-checking bench for the animation index track validator. A short
// table of hand-picked bytes runs first, then well-formed tracks with random
// content, some of them corrupted, cut short or replaced by noise, under a
// sequence of register settings. Every status item is compared with the table
// or a behavioural model of the parser kept inside the bench. Both channels
// idle at random, and the result side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module anim_index_track_validator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AFTER   = 600;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES  = 10;

    localparam logic [aitv_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [3:0]                       OP_NONE    = 4'd0;

    typedef struct packed {
        aitv_pkg::status_t status;
        logic              track_done;
    } verdict_t;

    typedef struct {
        logic [7:0]        data;
        logic              last;
        bit                known;
        aitv_pkg::status_t status;
    } directed_row_t;

    logic clk;
    logic rst_n;

    aitv_cfg_if cfg_if ();
    aitv_in_if  track_if ();
    aitv_out_if result_if ();

    anim_index_track_validator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .track  (track_if),
        .result (result_if)
    );

    // Register copies
    logic [7:0]  value_format_reg = 8'd0;
    logic [8:0]  table_count_reg  = 9'd1;
    logic        dispatch_reg     = 1'b0;

    // Parser state
    aitv_pkg::phase_t  phase           = aitv_pkg::PH_HEADER;
    bit                new_track       = 1'b1;
    logic [15:0]       owed_entries    = '0;
    logic [21:0]       varint_sum      = '0;
    logic [4:0]        varint_pos      = '0;
    logic [1:0]        value_bytes_due = '0;
    logic [31:0]       value_word      = '0;
    logic [1:0]        value_count     = '0;
    logic [3:0]        lead_op         = OP_NONE;
    aitv_pkg::status_t held_error      = aitv_pkg::ST_RUNNING;

    verdict_t    verdicts_due [$];
    verdict_t    due_now;
    logic [7:0]  track_bytes [$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;

    directed_row_t directed_rows [25] = '{
        '{8'h06, 1'b0, 1'b1, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b1, 1'b1, aitv_pkg::ST_VALID},
        '{8'h01, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h80, 1'b1, 1'b1, aitv_pkg::ST_TOO_FEW},
        '{8'hFF, 1'b1, 1'b1, aitv_pkg::ST_BAD_OPCODE},
        '{8'h86, 1'b1, 1'b1, aitv_pkg::ST_TRUNCATED},
        '{8'h06, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h80, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h3F, 1'b1, 1'b1, aitv_pkg::ST_OUT_OF_TABLE},
        '{8'hF6, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'hFF, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'hFF, 1'b1, 1'b1, aitv_pkg::ST_VARINT_LIMIT},
        '{8'h16, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b0, 1'b0, aitv_pkg::ST_RUNNING},
        '{8'h00, 1'b1, 1'b1, aitv_pkg::ST_PKT_TRUNC}
    };

    function automatic void latch_error(aitv_pkg::status_t code);
        if (held_error == aitv_pkg::ST_RUNNING) held_error = code;
    endfunction

    function automatic void append_byte(logic [7:0] b);
        track_bytes.insert(track_bytes.size(), b);
    endfunction

    function automatic int unsigned value_width();
        if (value_format_reg == 8'd0) return 4;
        return (value_format_reg[7:5] == aitv_pkg::TY_INT16 ||
                value_format_reg[7:5] == aitv_pkg::TY_UINT16) ? 2 : 1;
    endfunction

    function automatic bit index_fits(logic [31:0] v);
        logic [31:0] lim;
        lim = (table_count_reg > aitv_pkg::TABLE_MAX) ? 32'(aitv_pkg::TABLE_MAX)
                                                      : 32'(table_count_reg);
        return dispatch_reg || (v < lim);
    endfunction

    function automatic void open_value();
        phase           = aitv_pkg::PH_VALUE;
        value_bytes_due = 2'(value_width() - 1);
        value_word      = '0;
    endfunction

    function automatic void close_track();
        if (owed_entries != 16'd0)
            latch_error(aitv_pkg::ST_PKT_TRUNC);
        else if (!(value_count >= 2'd2 ||
                   (value_count == 2'd1 && lead_op == aitv_pkg::OP_KEY)))
            latch_error(aitv_pkg::ST_TOO_FEW);
    endfunction

    function automatic void count_ended(logic last);
        owed_entries = varint_sum[15:0];
        if (last) latch_error(aitv_pkg::ST_TRUNCATED);
        else open_value();
    endfunction

    function automatic void wait_ended(logic last);
        if (last) close_track();
        else if (owed_entries != 16'd0) open_value();
        else phase = aitv_pkg::PH_HEADER;
    endfunction

    function automatic verdict_t track_status_for(logic [7:0] b, logic last);
        logic [31:0] raw;
        logic [31:0] full;
        logic [31:0] v;
        logic [7:0]  e;
        int          sh;
        int          frac;
        bit          ok;
        verdict_t    res;
        if (new_track)
        begin
            phase           = aitv_pkg::PH_HEADER;
            owed_entries    = '0;
            varint_sum      = '0;
            varint_pos      = '0;
            value_bytes_due = '0;
            value_word      = '0;
            value_count     = '0;
            lead_op         = OP_NONE;
            held_error      = aitv_pkg::ST_RUNNING;
            new_track       = 1'b0;
        end
        if (held_error == aitv_pkg::ST_RUNNING)
        begin
            if (table_count_reg == 9'd0)
                latch_error(aitv_pkg::ST_NO_TABLE);
            else if (!(value_format_reg == 8'd0 ||
                       (value_format_reg[7:5] >= aitv_pkg::TY_INT16 &&
                        value_format_reg[7:5] <= aitv_pkg::TY_UINT8 &&
                        value_format_reg[4:0] != aitv_pkg::FRAC_INVALID)))
                latch_error(aitv_pkg::ST_BAD_FORMAT);
            else
            begin
                case (phase)
                    aitv_pkg::PH_COUNT, aitv_pkg::PH_WAIT_CONT:
                    begin
                        varint_sum = 22'(32'(varint_sum) + (32'(b[6:0]) << varint_pos[3:0]));
                        varint_pos = varint_pos + 5'd7;
                        if (varint_sum > 22'd65535)
                            latch_error(aitv_pkg::ST_VARINT_LIMIT);
                        else if (b[7])
                        begin
                            if (varint_pos >= 5'd16) latch_error(aitv_pkg::ST_VARINT_LIMIT);
                            else if (last) latch_error(aitv_pkg::ST_TRUNCATED);
                        end
                        else if (phase == aitv_pkg::PH_COUNT)
                            count_ended(last);
                        else
                            wait_ended(last);
                    end
                    aitv_pkg::PH_VALUE:
                    begin
                        value_word = {b, value_word[31:8]};
                        if (value_bytes_due != 2'd0)
                        begin
                            value_bytes_due--;
                            if (last) latch_error(aitv_pkg::ST_TRUNCATED);
                        end
                        else
                        begin
                            raw = value_word >> (8 * (4 - value_width()));
                            ok  = 1'b0;
                            if (value_format_reg == 8'd0)
                            begin
                                e = raw[30:23];
                                if (e == aitv_pkg::EXP_SPECIAL)
                                    ok = 1'b0;
                                else if (raw[30:0] == 31'd0)
                                    ok = index_fits(32'd0);
                                else if (!raw[31] && e >= aitv_pkg::EXP_ONE &&
                                         e <= aitv_pkg::EXP_MAX)
                                begin
                                    sh   = int'(aitv_pkg::EXP_POINT) - int'(e);
                                    full = {9'd0, 1'b1, raw[22:0]};
                                    ok   = ((full & ((32'd1 << sh) - 32'd1)) == 32'd0)
                                           && index_fits(full >> sh);
                                end
                            end
                            else
                            begin
                                frac = int'(value_format_reg[4:0]);
                                if (value_format_reg[7:5] == aitv_pkg::TY_INT16 ||
                                    value_format_reg[7:5] == aitv_pkg::TY_UINT16)
                                    v = {16'd0, raw[15:0]};
                                else
                                    v = {24'd0, raw[7:0]};
                                ok = !((value_format_reg[7:5] == aitv_pkg::TY_INT16 && raw[15]) ||
                                       (value_format_reg[7:5] == aitv_pkg::TY_INT8 && raw[7]))
                                     && ((v & ((32'd1 << frac) - 32'd1)) == 32'd0)
                                     && index_fits(v >> frac);
                            end
                            if (!ok)
                                latch_error(aitv_pkg::ST_OUT_OF_TABLE);
                            else
                            begin
                                if (owed_entries != 16'd0) owed_entries--;
                                if (value_count < 2'd2) value_count++;
                                if (last) close_track();
                                else phase = aitv_pkg::PH_WAIT_START;
                            end
                        end
                    end
                    aitv_pkg::PH_WAIT_START:
                    begin
                        varint_sum = 22'(b[6:0]);
                        varint_pos = 5'd7;
                        if (b[7])
                        begin
                            if (last) latch_error(aitv_pkg::ST_TRUNCATED);
                            else phase = aitv_pkg::PH_WAIT_CONT;
                        end
                        else
                            wait_ended(last);
                    end
                    default:
                    begin
                        if (b[3:0] != aitv_pkg::OP_CONSTANT && b[3:0] != aitv_pkg::OP_KEY)
                            latch_error(aitv_pkg::ST_BAD_OPCODE);
                        else
                        begin
                            if (lead_op == OP_NONE) lead_op = b[3:0];
                            varint_sum = 22'(b[6:4]) + 22'd1;
                            if (b[7])
                            begin
                                varint_pos = 5'd3;
                                if (last) latch_error(aitv_pkg::ST_TRUNCATED);
                                else phase = aitv_pkg::PH_COUNT;
                            end
                            else
                                count_ended(last);
                        end
                    end
                endcase
            end
        end
        res.status     = (held_error != aitv_pkg::ST_RUNNING) ? held_error :
                         (last ? aitv_pkg::ST_VALID : aitv_pkg::ST_RUNNING);
        res.track_done = last;
        if (last) new_track = 1'b1;
        return res;
    endfunction

    function automatic void push_groups(int unsigned x);
        do
        begin
            append_byte({x > 127, 7'(x & 127)});
            x = x >> 7;
        end
        while (x != 0);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 15) return 0;
        if (r < 19) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap);
        if (gap != 0)
        begin
            track_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        track_if.valid     <= 1'b1;
        track_if.data_byte <= b;
        track_if.last_byte <= last;
        @(posedge clk);
        while (track_if.ready !== 1'b1) @(posedge clk);
    endtask

    task automatic write_register(input logic [aitv_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [aitv_pkg::CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        case (idx)
            aitv_pkg::CFG_VALUE_FORMAT:    value_format_reg = value[7:0];
            aitv_pkg::CFG_TABLE_COUNT:     table_count_reg  = value;
            aitv_pkg::CFG_DISPATCHED_ONLY: dispatch_reg     = value[0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : result_sink
        int unsigned run;
        int unsigned gap;
        bit          held;
        held = 1'b0;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER)
            begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
            result_if.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap != 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            results_seen++;
            if (verdicts_due.size() == 0)
            begin
                $error("result item with nothing expected: status %0d", result_if.status);
                mismatches++;
            end
            else
            begin
                due_now = verdicts_due.pop_front();
                if (result_if.status !== due_now.status)
                begin
                    $error("status: expected %0d, got %0d", due_now.status, result_if.status);
                    mismatches++;
                end
                if (result_if.track_done !== due_now.track_done)
                begin
                    $error("track_done: expected %0d, got %0d",
                           due_now.track_done, result_if.track_done);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((track_if.valid === 1'b1 && track_if.ready === 1'b1) ||
            (result_if.valid === 1'b1 && result_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("anim_index_track_validator_test NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned packets;
        int unsigned entries;
        int unsigned rest;
        int unsigned lim;
        int unsigned pick;
        int unsigned cap;
        int unsigned frac;
        int unsigned msb;
        int unsigned w;
        int unsigned nbytes;
        int unsigned tail_mark;
        int unsigned keep;
        int unsigned phase_no;
        int unsigned sent;
        int          budget;
        int          r;
        int          p;
        int          k;
        int          j;
        logic [7:0]  fmt;
        logic [8:0]  tables;
        logic        disp;
        logic [3:0]  op;
        logic [31:0] word;
        logic        last;
        bit          calm;
        verdict_t    due;

        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        track_if.valid     <= 1'b0;
        track_if.data_byte <= 8'd0;
        track_if.last_byte <= 1'b0;
        @(posedge rst_n);

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data, directed_rows[i].last, pick_gap());
            due = track_status_for(directed_rows[i].data, directed_rows[i].last);
            if (directed_rows[i].known) due.status = directed_rows[i].status;
            verdicts_due.insert(verdicts_due.size(), due);
        end
        track_if.valid <= 1'b0;

        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            case (phase_no)
                0:
                begin
                    fmt = 8'd0; tables = aitv_pkg::TABLE_MAX; disp = 1'b0;
                end
                1:
                begin
                    fmt = {aitv_pkg::TY_UINT16, 5'd0}; tables = 9'd511; disp = 1'b0;
                end
                2:
                begin
                    fmt = {aitv_pkg::TY_INT8, 5'd2}; tables = 9'd1; disp = 1'b1;
                end
                3:
                begin
                    fmt = {aitv_pkg::TY_INT16, aitv_pkg::FRAC_INVALID}; tables = 9'd100;
                    disp = 1'b0;
                end
                4:
                begin
                    fmt = 8'hFF; tables = 9'd0; disp = 1'b1;
                end
                5:
                begin
                    fmt = {aitv_pkg::TY_UINT8, 5'd30}; tables = 9'd300; disp = 1'b1;
                end
                6:
                begin
                    fmt = 8'd0; tables = aitv_pkg::TABLE_MAX; disp = 1'b1;
                end
                default:
                begin
                    r = $urandom_range(0, 19);
                    if (r < 3)
                        fmt = 8'd0;
                    else if (r < 16)
                        fmt = {3'($urandom_range(aitv_pkg::TY_INT16, aitv_pkg::TY_UINT8)),
                               5'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) :
                                                               $urandom_range(0, 30))};
                    else if (r < 18)
                        fmt = {3'($urandom_range(aitv_pkg::TY_INT16, aitv_pkg::TY_UINT8)),
                               aitv_pkg::FRAC_INVALID};
                    else
                        fmt = 8'($urandom);
                    r = $urandom_range(0, 19);
                    if (r == 0)     tables = 9'd0;
                    else if (r < 3) tables = 9'($urandom_range(257, 511));
                    else if (r < 5) tables = 9'd1;
                    else            tables = 9'($urandom_range(2, 256));
                    disp = ($urandom_range(0, 3) == 0);
                end
            endcase
            write_register(aitv_pkg::CFG_VALUE_FORMAT, {1'b0, fmt});
            write_register(aitv_pkg::CFG_TABLE_COUNT, tables);
            write_register(aitv_pkg::CFG_DISPATCHED_ONLY, {8'd0, disp});
            if ($urandom_range(0, 3) == 0) write_register(CFG_UNUSED, 9'($urandom));
            cfg_if.valid <= 1'b0;

            budget = (phase_no == 3 || phase_no == 4) ? 30 : $urandom_range(100, 200);
            calm   = ($urandom_range(0, 3) == 0);
            while (budget > 0)
            begin
                track_bytes.delete();
                tail_mark = 0;
                packets   = $urandom_range(1, 3);
                for (p = 0; p < packets; p++)
                begin
                    op      = $urandom_range(0, 1) ? aitv_pkg::OP_KEY : aitv_pkg::OP_CONSTANT;
                    entries = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                                                            $urandom_range(1, 4);
                    rest    = (entries - 1) >> 3;
                    append_byte({rest != 0, 3'((entries - 1) & 7), op});
                    if (rest != 0) push_groups(rest);
                    for (k = 0; k < entries; k++)
                    begin
                        lim = dispatch_reg ? 65536 :
                              ((table_count_reg > aitv_pkg::TABLE_MAX) ?
                               32'(aitv_pkg::TABLE_MAX) : 32'(table_count_reg));
                        if (lim == 0) lim = 1;
                        pick = ($urandom_range(0, 4) == 0) ? lim - 1 : $urandom_range(0, lim - 1);
                        nbytes = value_width();
                        if (value_format_reg == 8'd0)
                        begin
                            if (pick == 0)
                                word = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
                            else
                            begin
                                msb = 0;
                                for (j = 0; j < 16; j++) if (pick[j]) msb = j;
                                word = {1'b0, 8'(int'(aitv_pkg::EXP_ONE) + msb),
                                        23'(pick << (23 - msb))};
                            end
                            if ($urandom_range(0, 19) == 0)
                            begin
                                case ($urandom_range(0, 5))
                                    0:       word = 32'h7F80_0000;
                                    1:       word = 32'h7FC0_0001;
                                    2:       word = 32'hBF80_0000;
                                    3:       word = 32'h3FC0_0000;
                                    4:       word = 32'h4780_0000;
                                    default: word = $urandom;
                                endcase
                            end
                        end
                        else
                        begin
                            frac = 32'(value_format_reg[4:0]);
                            case (value_format_reg[7:5])
                                aitv_pkg::TY_INT16:  cap = 32'h7FFF;
                                aitv_pkg::TY_UINT16: cap = 32'hFFFF;
                                aitv_pkg::TY_INT8:   cap = 32'h7F;
                                default:             cap = 32'hFF;
                            endcase
                            cap = cap >> frac;
                            if (pick > cap) pick = $urandom_range(0, cap);
                            word = pick << frac;
                            if ($urandom_range(0, 19) == 0) word = $urandom;
                        end
                        for (j = 0; j < nbytes; j++) append_byte(word[8*j +: 8]);
                        tail_mark = track_bytes.size();
                        r = $urandom_range(0, 19);
                        if (r < 14)      w = $urandom_range(0, 127);
                        else if (r < 19) w = $urandom_range(128, 16383);
                        else             w = $urandom_range(16384, 65535);
                        push_groups(w);
                    end
                end
                // drop the trailing wait on most tracks
                if ($urandom_range(0, 9) < 7)
                    while (track_bytes.size() > tail_mark) void'(track_bytes.pop_back());

                case ($urandom_range(0, 19))
                    0, 1: track_bytes[$urandom_range(0, track_bytes.size() - 1)] = 8'($urandom);
                    2, 3:
                    begin
                        keep = $urandom_range(1, track_bytes.size());
                        while (track_bytes.size() > keep) void'(track_bytes.pop_back());
                    end
                    4:
                    begin
                        track_bytes.delete();
                        repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
                    end
                    default: ;
                endcase

                for (j = 0; j < track_bytes.size(); j++)
                begin
                    last = (j == track_bytes.size() - 1);
                    send_byte(track_bytes[j], last, calm ? 0 : pick_gap());
                    due = track_status_for(track_bytes[j], last);
                    verdicts_due.insert(verdicts_due.size(), due);
                end
                budget -= track_bytes.size();
                sent   += track_bytes.size();
            end
            track_if.valid <= 1'b0;
            phase_no++;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("anim_index_track_validator_test OK");
        else
            $display("anim_index_track_validator_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/aitv_pkg.sv
src/aitv_cfg_if.sv
src/aitv_in_if.sv
src/aitv_out_if.sv
src/anim_index_track_validator.sv
sim/anim_index_track_validator_test.sv
